### src/cantxq_pkg.sv
// Package for the CAN transmit frame queue: field widths, item codes,
// sender state codes and the stored entry layout. No dependencies.
`timescale 1ns / 1ps

package cantxq_pkg;

   // field widths
   localparam int ID_W     = 29;
   localparam int STD_ID_W = 11;
   localparam int LEN_W    = 4;
   localparam int DATA_W   = 64;
   localparam int BYTES    = DATA_W / 8;
   localparam int OVF_W    = 16;
   localparam int PEND_W   = 5;

   // longest frame in bytes
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(BYTES);

   // input item codes
   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_POLL    = 1'b1;

   // sender states
   localparam logic SEND_IDLE = 1'b0;
   localparam logic SEND_WAIT = 1'b1;

   // one queued frame as kept in the ring
   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic              ext;
      logic [ID_W-1:0]   id;
      logic [DATA_W-1:0] data;
   } entry_type;

endpackage

### src/can_tx_frame_queue.sv
// CAN transmit frame queue: ring of DEPTH frames, overflow flush, two-state sender.
// Uses cantxq_pkg and cantxq_ram. An accepted word passes through the input register
// into the result register, where it waits while rsp_ready is low. Throughput: one word per
// cycle while rsp_ready is high; the two registers bound one pass of logic.
// Reset (synchronous, active high) empties the ring, idles the sender and clears
// the overflow count; ring contents stay undefined until written.
`timescale 1ns / 1ps

module can_tx_frame_queue #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic [cantxq_pkg::ID_W-1:0]         req_frame_id,
   input  logic                                req_frame_extended,
   input  logic [cantxq_pkg::LEN_W-1:0]        req_frame_len,
   input  logic [cantxq_pkg::DATA_W-1:0]       req_frame_data,
   input  logic                                req_tx_complete,
   input  logic                                req_bus_off,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_enqueue_accepted,
   output logic                                rsp_tx_start,
   output logic [cantxq_pkg::ID_W-1:0]         rsp_tx_id,
   output logic                                rsp_tx_extended,
   output logic [cantxq_pkg::LEN_W-1:0]        rsp_tx_len,
   output logic [cantxq_pkg::DATA_W-1:0]       rsp_tx_data,
   output logic [cantxq_pkg::OVF_W-1:0]        rsp_overflow_count,
   output logic                                rsp_reinit_request,
   output logic [cantxq_pkg::PEND_W-1:0]       rsp_pending_count
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int ENT_W = $bits(cantxq_pkg::entry_type);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   // frames waiting between a read and a write position
   function automatic logic [CNT_W-1:0] pend_of(
      input logic [IDX_W-1:0] w_idx, input logic w_wrap,
      input logic [IDX_W-1:0] r_idx, input logic r_wrap);
      logic [CNT_W-1:0] diff;
      diff = CNT_W'(w_idx) - CNT_W'(r_idx);
      if (w_wrap != r_wrap) begin
         diff = diff + FULL_CNT;
      end
      return diff;
   endfunction

   // input register
   logic                                 s1_valid_ff, s1_valid_in;
   logic                                 s1_action_ff;
   logic [cantxq_pkg::ID_W-1:0]          s1_id_ff;
   logic                                 s1_ext_ff;
   logic [cantxq_pkg::LEN_W-1:0]         s1_len_ff;
   logic [cantxq_pkg::DATA_W-1:0]        s1_data_ff;
   logic                                 s1_complete_ff;
   logic                                 s1_bus_off_ff;

   // queue and sender state
   logic [IDX_W-1:0]                     wr_idx_ff, wr_idx_in;
   logic                                 wr_wrap_ff, wr_wrap_in;
   logic [IDX_W-1:0]                     rd_idx_ff, rd_idx_in;
   logic                                 rd_wrap_ff, rd_wrap_in;
   logic                                 send_state_ff, send_state_in;
   logic [cantxq_pkg::OVF_W-1:0]         ovf_ff, ovf_in;

   // result register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 acc_ff, acc_in;
   logic                                 start_ff, start_in;
   logic [cantxq_pkg::ID_W-1:0]          tid_ff, tid_in;
   logic                                 text_ff, text_in;
   logic [cantxq_pkg::LEN_W-1:0]         tlen_ff, tlen_in;
   logic [cantxq_pkg::DATA_W-1:0]        tdata_ff, tdata_in;
   logic                                 reinit_ff, reinit_in;
   logic [cantxq_pkg::PEND_W-1:0]        pend_ff, pend_in;

   // head-of-queue read path with write forwarding
   logic                                 byp_ff, byp_in;
   cantxq_pkg::entry_type                byp_data_ff;
   cantxq_pkg::entry_type                ram_rdata, head, wr_entry;
   logic                                 ram_we;

   logic                                 fire;
   logic [CNT_W-1:0]                     cur_pend;
   logic                                 full;
   logic [cantxq_pkg::LEN_W-1:0]         len_sat;
   logic [cantxq_pkg::ID_W-1:0]          id_clean;
   logic [cantxq_pkg::DATA_W-1:0]        data_clean;

   // handshake: advance the input word when the result register is free
   assign fire      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || fire;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);

   assign cur_pend = pend_of(wr_idx_ff, wr_wrap_ff, rd_idx_ff, rd_wrap_ff);
   assign full     = (cur_pend == FULL_CNT);

   // clean the incoming frame: saturate length, trim id, zero unused bytes
   always_comb begin
      len_sat = (s1_len_ff > cantxq_pkg::MAX_LEN) ? cantxq_pkg::MAX_LEN : s1_len_ff;
      id_clean = s1_id_ff;
      if (!s1_ext_ff) begin
         id_clean[cantxq_pkg::ID_W-1:cantxq_pkg::STD_ID_W] = '0;
      end
      for (int i = 0; i < cantxq_pkg::BYTES; i++) begin
         data_clean[i*8 +: 8] =
            (cantxq_pkg::LEN_W'(i) < len_sat) ? s1_data_ff[i*8 +: 8] : 8'h00;
      end
      wr_entry.len  = len_sat;
      wr_entry.ext  = s1_ext_ff;
      wr_entry.id   = id_clean;
      wr_entry.data = data_clean;
   end

   assign head = byp_ff ? byp_data_ff : ram_rdata;

   // one pass: update pointers, sender and counter, build the result word
   always_comb begin
      wr_idx_in     = wr_idx_ff;
      wr_wrap_in    = wr_wrap_ff;
      rd_idx_in     = rd_idx_ff;
      rd_wrap_in    = rd_wrap_ff;
      send_state_in = send_state_ff;
      ovf_in        = ovf_ff;
      ram_we        = 1'b0;
      acc_in        = 1'b0;
      start_in      = 1'b0;
      tid_in        = '0;
      text_in       = 1'b0;
      tlen_in       = '0;
      tdata_in      = '0;
      reinit_in     = 1'b0;
      if (fire) begin
         if (s1_action_ff == cantxq_pkg::ACT_ENQUEUE) begin
            if (full) begin
               // drop the frame and flush the ring
               rd_idx_in  = wr_idx_ff;
               rd_wrap_in = wr_wrap_ff;
               if (ovf_ff != '1) begin
                  ovf_in = ovf_ff + 1'b1;
               end
            end else begin
               ram_we = 1'b1;
               acc_in = 1'b1;
               if (wr_idx_ff == LAST_IDX) begin
                  wr_idx_in  = '0;
                  wr_wrap_in = !wr_wrap_ff;
               end else begin
                  wr_idx_in = wr_idx_ff + 1'b1;
               end
            end
         end else begin
            if (send_state_ff == cantxq_pkg::SEND_IDLE) begin
               if (cur_pend != '0) begin
                  // pop the oldest frame and start it
                  start_in      = 1'b1;
                  tid_in        = head.id;
                  text_in       = head.ext;
                  tlen_in       = head.len;
                  tdata_in      = head.data;
                  send_state_in = cantxq_pkg::SEND_WAIT;
                  if (rd_idx_ff == LAST_IDX) begin
                     rd_idx_in  = '0;
                     rd_wrap_in = !rd_wrap_ff;
                  end else begin
                     rd_idx_in = rd_idx_ff + 1'b1;
                  end
               end
            end else if (s1_complete_ff) begin
               send_state_in = cantxq_pkg::SEND_IDLE;
            end
            reinit_in = s1_bus_off_ff;
         end
      end
      pend_in = cantxq_pkg::PEND_W'(pend_of(wr_idx_in, wr_wrap_in, rd_idx_in, rd_wrap_in));
      byp_in  = ram_we && (wr_idx_ff == rd_idx_in);
   end

   // ring storage, read continuously at the next head position
   cantxq_ram #(
      .WIDTH (ENT_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx_ff),
      .wr_data (wr_entry),
      .rd_addr (rd_idx_in),
      .rd_data (ram_rdata)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         wr_idx_ff     <= '0;
         wr_wrap_ff    <= 1'b0;
         rd_idx_ff     <= '0;
         rd_wrap_ff    <= 1'b0;
         send_state_ff <= cantxq_pkg::SEND_IDLE;
         ovf_ff        <= '0;
         byp_ff        <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         wr_idx_ff     <= wr_idx_in;
         wr_wrap_ff    <= wr_wrap_in;
         rd_idx_ff     <= rd_idx_in;
         rd_wrap_ff    <= rd_wrap_in;
         send_state_ff <= send_state_in;
         ovf_ff        <= ovf_in;
         byp_ff        <= byp_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_action_ff   <= req_action;
         s1_id_ff       <= req_frame_id;
         s1_ext_ff      <= req_frame_extended;
         s1_len_ff      <= req_frame_len;
         s1_data_ff     <= req_frame_data;
         s1_complete_ff <= req_tx_complete;
         s1_bus_off_ff  <= req_bus_off;
      end
      byp_data_ff <= wr_entry;
      if (fire) begin
         acc_ff    <= acc_in;
         start_ff  <= start_in;
         tid_ff    <= tid_in;
         text_ff   <= text_in;
         tlen_ff   <= tlen_in;
         tdata_ff  <= tdata_in;
         reinit_ff <= reinit_in;
         pend_ff   <= pend_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_enqueue_accepted = acc_ff;
   assign rsp_tx_start         = start_ff;
   assign rsp_tx_id            = tid_ff;
   assign rsp_tx_extended      = text_ff;
   assign rsp_tx_len           = tlen_ff;
   assign rsp_tx_data          = tdata_ff;
   assign rsp_overflow_count   = ovf_ff;
   assign rsp_reinit_request   = reinit_ff;
   assign rsp_pending_count    = pend_ff;

   // the ring never holds more than DEPTH frames
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      cur_pend <= FULL_CNT)
      else $error("queue occupancy above depth");

   // a result word never both stores and starts a frame
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_enqueue_accepted && rsp_tx_start))
      else $error("result word both stored and started a frame");

   // a started frame puts the sender into the waiting state
   a_start_waits: assert property (@(posedge clock) disable iff (reset)
      (fire && start_in) |=> (send_state_ff == cantxq_pkg::SEND_WAIT))
      else $error("sender not waiting after a start");

   // a pop only happens from idle with frames pending
   a_pop_legal: assert property (@(posedge clock) disable iff (reset)
      (fire && start_in) |-> (send_state_ff == cantxq_pkg::SEND_IDLE && cur_pend != '0))
      else $error("frame started from an empty queue or while waiting");

endmodule

### src/cantxq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Reads return the old contents on a same-address write. No dependencies.
`timescale 1ns / 1ps

module cantxq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sim/can_tx_frame_queue_checker.sv
// Checker for the CAN transmit frame queue: watches both channels, models the
// ring, flush and sender state, and compares every response word. Uses cantxq_pkg.
`timescale 1ns / 1ps

module can_tx_frame_queue_checker
   import cantxq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_action,
   input  logic [ID_W-1:0]   req_frame_id,
   input  logic              req_frame_extended,
   input  logic [LEN_W-1:0]  req_frame_len,
   input  logic [DATA_W-1:0] req_frame_data,
   input  logic              req_tx_complete,
   input  logic              req_bus_off,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              rsp_enqueue_accepted,
   input  logic              rsp_tx_start,
   input  logic [ID_W-1:0]   rsp_tx_id,
   input  logic              rsp_tx_extended,
   input  logic [LEN_W-1:0]  rsp_tx_len,
   input  logic [DATA_W-1:0] rsp_tx_data,
   input  logic [OVF_W-1:0]  rsp_overflow_count,
   input  logic              rsp_reinit_request,
   input  logic [PEND_W-1:0] rsp_pending_count,
   output int                fail_count,
   output int                outstanding
);

   localparam int PTR_SPAN = 2 * DEPTH;
   localparam logic [ID_W-1:0] STD_ID_MASK = {{(ID_W-STD_ID_W){1'b0}}, {STD_ID_W{1'b1}}};

   // one response word as the queue should report it
   typedef struct packed {
      logic              accepted;
      logic              start;
      logic [ID_W-1:0]   id;
      logic              ext;
      logic [LEN_W-1:0]  len;
      logic [DATA_W-1:0] data;
      logic [OVF_W-1:0]  flushes;
      logic              reinit;
      logic [PEND_W-1:0] waiting;
   } queue_status_type;

   // model of the ring and the sender
   entry_type     ring [DEPTH];
   int            head;
   int            tail;
   logic          sender_busy;
   logic [OVF_W-1:0] flush_total;
   queue_status_type awaited_status [$];

   function automatic int frames_waiting();
      return (tail - head + PTR_SPAN) % PTR_SPAN;
   endfunction

   function automatic int field_differs(string field, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         return 1;
      end
      return 0;
   endfunction

   // advance the model by one request word and queue the status it yields
   task automatic predict_status(logic action, logic [ID_W-1:0] id, logic ext,
                                 logic [LEN_W-1:0] len, logic [DATA_W-1:0] data,
                                 logic complete, logic bus_off);
      queue_status_type st;
      entry_type     e;
      st = '0;
      if (action == ACT_ENQUEUE) begin
         if (frames_waiting() >= DEPTH) begin
            // full ring: drop the frame and flush everything
            head = tail;
            if (flush_total != '1) flush_total++;
         end else begin
            e.len  = (len > MAX_LEN) ? MAX_LEN : len;
            e.ext  = ext;
            e.id   = ext ? id : (id & STD_ID_MASK);
            e.data = data;
            for (int b = 0; b < BYTES; b++)
               if (b >= e.len) e.data[8*b +: 8] = 8'h00;
            ring[tail % DEPTH] = e;
            tail = (tail + 1) % PTR_SPAN;
            st.accepted = 1'b1;
         end
      end else begin
         if (sender_busy == SEND_IDLE) begin
            if (frames_waiting() > 0) begin
               e        = ring[head % DEPTH];
               st.start = 1'b1;
               st.id    = e.id;
               st.ext   = e.ext;
               st.len   = e.len;
               st.data  = e.data;
               head = (head + 1) % PTR_SPAN;
               sender_busy = SEND_WAIT;
            end
         end else if (complete) begin
            // completion only frees the sender, no pop in the same poll
            sender_busy = SEND_IDLE;
         end
         st.reinit = bus_off;
      end
      st.flushes = flush_total;
      st.waiting = PEND_W'(frames_waiting());
      awaited_status.push_back(st);
   endtask

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // retire responses first, then record the request of this edge
   always @(posedge clock) begin
      queue_status_type want;
      int            errs;
      if (reset) begin
         head        = 0;
         tail        = 0;
         sender_busy = SEND_IDLE;
         flush_total = '0;
         awaited_status.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_status.size() == 0) begin
               $display("%0t: response word with none expected, expected none, actual pend %0d",
                        $time, rsp_pending_count);
               fail_count++;
            end else begin
               want = awaited_status.pop_front();
               errs = 0;
               errs += field_differs("enqueue_accepted", want.accepted, rsp_enqueue_accepted);
               errs += field_differs("tx_start", want.start, rsp_tx_start);
               errs += field_differs("tx_id", want.id, rsp_tx_id);
               errs += field_differs("tx_extended", want.ext, rsp_tx_extended);
               errs += field_differs("tx_len", want.len, rsp_tx_len);
               errs += field_differs("tx_data", want.data, rsp_tx_data);
               errs += field_differs("overflow_count", want.flushes, rsp_overflow_count);
               errs += field_differs("reinit_request", want.reinit, rsp_reinit_request);
               errs += field_differs("pending_count", want.waiting, rsp_pending_count);
               if (errs != 0) fail_count++;
            end
         end
         if (req_valid && req_ready)
            predict_status(req_action, req_frame_id, req_frame_extended, req_frame_len,
                           req_frame_data, req_tx_complete, req_bus_off);
      end
      outstanding = awaited_status.size();
   end

endmodule

### sim/tb_can_tx_frame_queue.sv
// Testbench top for the CAN transmit frame queue: clock, reset, request and
// response stimulus, verdict. Uses cantxq_pkg, can_tx_frame_queue and its checker.
`timescale 1ns / 1ps

module tb_can_tx_frame_queue;
   import cantxq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int RANDOM_WORDS = 600;
   localparam int CYCLE_LIMIT = 200000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_action;
   logic [ID_W-1:0]   req_frame_id;
   logic              req_frame_extended;
   logic [LEN_W-1:0]  req_frame_len;
   logic [DATA_W-1:0] req_frame_data;
   logic              req_tx_complete;
   logic              req_bus_off;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_enqueue_accepted;
   logic              rsp_tx_start;
   logic [ID_W-1:0]   rsp_tx_id;
   logic              rsp_tx_extended;
   logic [LEN_W-1:0]  rsp_tx_len;
   logic [DATA_W-1:0] rsp_tx_data;
   logic [OVF_W-1:0]  rsp_overflow_count;
   logic              rsp_reinit_request;
   logic [PEND_W-1:0] rsp_pending_count;

   int   fail_count;
   int   outstanding;
   int   cycle_count;
   logic steady;

   can_tx_frame_queue #(.DEPTH(DEPTH)) dut (.*);

   can_tx_frame_queue_checker #(.DEPTH(DEPTH)) checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // stall the response side at random outside the steady stretch
   always @(negedge clock)
      rsp_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 26);

   // present one word, idling first at random, and hold it until accepted
   task automatic send_word(logic action, logic [ID_W-1:0] id, logic ext,
                            logic [LEN_W-1:0] len, logic [DATA_W-1:0] data,
                            logic complete, logic bus_off);
      while (!steady && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_action         <= action;
      req_frame_id       <= id;
      req_frame_extended <= ext;
      req_frame_len      <= len;
      req_frame_data     <= data;
      req_tx_complete    <= complete;
      req_bus_off        <= bus_off;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // enqueue word; sender flags carry random noise
   task automatic enqueue_frame(logic [ID_W-1:0] id, logic ext, logic [LEN_W-1:0] len,
                                logic [DATA_W-1:0] data);
      send_word(ACT_ENQUEUE, id, ext, len, data, 1'($urandom), 1'($urandom));
   endtask

   // poll word; frame fields carry random noise
   task automatic poll_sender(logic complete, logic bus_off);
      send_word(ACT_POLL, ID_W'($urandom), 1'($urandom), LEN_W'($urandom),
                {$urandom, $urandom}, complete, bus_off);
   endtask

   function automatic logic [LEN_W-1:0] pick_len();
      if ($urandom_range(0, 99) < 20) return LEN_W'($urandom_range(9, 15));
      return LEN_W'($urandom_range(0, 8));
   endfunction

   initial begin
      int block_left;
      int enqueue_bias;
      req_valid          = 1'b0;
      req_action         = ACT_ENQUEUE;
      req_frame_id       = '0;
      req_frame_extended = 1'b0;
      req_frame_len      = '0;
      req_frame_data     = '0;
      req_tx_complete    = 1'b0;
      req_bus_off        = 1'b0;
      rsp_ready          = 1'b0;
      steady             = 1'b0;
      reset              = 1'b1;
      block_left         = 0;
      enqueue_bias       = 50;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // poll an empty queue
      poll_sender(1'b1, 1'b0);
      // standard id gets truncated, zero length clears all data
      enqueue_frame('1, 1'b0, 4'd0, '1);
      enqueue_frame('1, 1'b1, MAX_LEN, '1);
      // lengths above eight saturate
      enqueue_frame(ID_W'($urandom), 1'b0, 4'd15, {$urandom, $urandom});
      enqueue_frame('0, 1'b1, 4'd9, '1);
      enqueue_frame('0, 1'b0, 4'd3, '1);
      // start with bus-off, hold while waiting, complete without a pop
      poll_sender(1'b0, 1'b1);
      poll_sender(1'b0, 1'b0);
      poll_sender(1'b1, 1'b1);
      poll_sender(1'b0, 1'b0);
      poll_sender(1'b1, 1'b0);
      // fill the ring, then overflow it and flush
      repeat (14) enqueue_frame(ID_W'($urandom), 1'($urandom), pick_len(), {$urandom, $urandom});
      enqueue_frame(ID_W'($urandom), 1'b1, 4'd5, {$urandom, $urandom});
      poll_sender(1'b0, 1'b0);

      // random bursts, each leaning at random toward filling or draining the ring
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         steady = (n >= 200 && n < 300);
         if (n == 400) begin
            // hold the requests until every response has come back
            req_valid <= 1'b0;
            while (outstanding != 0) @(negedge clock);
         end
         if (block_left == 0) begin
            block_left = $urandom_range(10, 40);
            case ($urandom_range(0, 2))
               0: enqueue_bias = 85;
               1: enqueue_bias = 50;
               default: enqueue_bias = 20;
            endcase
         end
         block_left--;
         if ($urandom_range(0, 99) < enqueue_bias)
            enqueue_frame(ID_W'($urandom), 1'($urandom), pick_len(), {$urandom, $urandom});
         else
            poll_sender($urandom_range(0, 99) < 60, $urandom_range(0, 99) < 15);
      end
      steady = 1'b0;

      // drain and settle
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### sim.f
src/cantxq_pkg.sv
src/cantxq_ram.sv
src/can_tx_frame_queue.sv
sim/can_tx_frame_queue_checker.sv
sim/tb_can_tx_frame_queue.sv
